FILE: src/tsbs_pkg.sv
// Shared constants and types for the block sorter.
package tsbs_pkg;

    localparam int DATA_W            = 32;
    localparam int MAX_ITEMS_DEF     = 64;
    localparam int MIN_RUN_LIMIT_DEF = 64;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RUNLEN,
        ST_INS_RUN,
        ST_INS_OUTER,
        ST_INS_V,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_MRG_PASS,
        ST_MRG_PAIR,
        ST_MRG_FA,
        ST_MRG_WA,
        ST_MRG_WB,
        ST_MRG_CMP,
        ST_CPY,
        ST_CPY_END,
        ST_OUT,
        ST_OUT_END
    } t_state;

endpackage

FILE: src/timsort_block_sorter_unit.sv
// Top level of the block sorter: loads a set, sorts it by runs and merges, emits it.
//
// The block collects up to MAX_ITEMS signed values, one beat per cycle while busy
// is low, until a beat with i_last set arrives; beats beyond capacity are dropped
// and every result of that set then carries o_overflow. It then raises busy, sorts
// the stored set in ascending order and sends it out as one result beat per value,
// marked by o_valid for exactly one cycle each, with o_last_out on the final one.
// The receiver cannot stall the output, so the beats come on consecutive cycles.
// The sort works through the one read and one write port of the element memory
// and of a scratch memory: insertion sort orders each run in place, each merge
// pass merges pairs of runs into the scratch memory and copies them back, and
// there are log2(n / run) passes. The run length is found by one halving step
// per cycle. After the final result beat, busy drops.
module timsort_block_sorter_unit #(
    parameter int MAX_ITEMS     = tsbs_pkg::MAX_ITEMS_DEF,
    parameter int MIN_RUN_LIMIT = tsbs_pkg::MIN_RUN_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [tsbs_pkg::DATA_W-1:0] i_value,
    input  logic                               i_last,
    output logic                               o_valid,
    output logic signed [tsbs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                               o_last_out,
    output logic                               o_overflow
);

    import tsbs_pkg::*;

    // Address width of the memories, width of the item count, and a width for
    // positions that leaves room for sums such as lo plus twice the run size.
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = CW + 2;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [XW-1:0] r_run, n_run;
    logic          r_carry, n_carry;
    logic [XW-1:0] r_size, n_size;
    logic [XW-1:0] r_lo, n_lo;
    logic [XW-1:0] r_hi, n_hi;
    logic [XW-1:0] r_mid, n_mid;
    logic [XW-1:0] r_i, n_i;
    logic [XW-1:0] r_j, n_j;
    logic [XW-1:0] r_a, n_a;
    logic [XW-1:0] r_b, n_b;
    logic [XW-1:0] r_k, n_k;
    logic [XW-1:0] r_wk, n_wk;
    logic          r_cpv, n_cpv;
    logic          r_emit, n_emit;
    logic          r_elast, n_elast;
    logic signed [DATA_W-1:0] r_v, n_v;
    logic signed [DATA_W-1:0] r_va, n_va;
    logic signed [DATA_W-1:0] r_vb, n_vb;

    // Memory ports.
    logic              st_we, sc_we;
    logic [AW-1:0]     st_waddr, st_raddr, sc_waddr, sc_raddr;
    logic [DATA_W-1:0] st_wdata, st_rdata, sc_wdata, sc_rdata;

    // Derived positions.
    logic [CW-1:0] count_inc;
    logic [XW-1:0] n_ext, n_last;
    logic [XW-1:0] run_end, pair_mid, pair_end, pair_step;
    logic          take_b;

    tsbs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    tsbs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    assign count_inc = (r_count < CW'(MAX_ITEMS)) ? r_count + CW'(1) : r_count;
    assign n_ext     = {2'b00, r_count};
    assign n_last    = n_ext - XW'(1);
    assign run_end   = r_lo + r_run - XW'(1);
    assign pair_step = r_size << 1;
    assign pair_mid  = r_lo + r_size - XW'(1);
    assign pair_end  = r_lo + pair_step - XW'(1);

    // The merge takes from the right run only when the left run is used up or its
    // head is strictly greater, which keeps equal values in their original order.
    assign take_b = (r_a > r_mid) || ((r_b <= r_hi) && (r_va > r_vb));

    assign busy           = (r_state != ST_LOAD);
    assign o_valid        = r_emit;
    assign o_last_out     = r_elast;
    assign o_overflow     = r_drop;
    assign o_sorted_value = st_rdata;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_drop   = r_drop;
        n_run    = r_run;
        n_carry  = r_carry;
        n_size   = r_size;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_i      = r_i;
        n_j      = r_j;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_wk     = r_wk;
        n_cpv    = 1'b0;
        n_emit   = 1'b0;
        n_elast  = r_elast;
        n_v      = r_v;
        n_va     = r_va;
        n_vb     = r_vb;
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_raddr = '0;
        sc_we    = 1'b0;
        sc_waddr = '0;
        sc_wdata = '0;
        sc_raddr = '0;

        // Copy-back writes land in the cycle after their scratch read.
        if (r_cpv) begin
            st_we    = 1'b1;
            st_waddr = r_wk[AW-1:0];
            st_wdata = sc_rdata;
        end

        case (r_state)
            ST_LOAD: begin
                if (start) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        st_we    = 1'b1;
                        st_waddr = r_count[AW-1:0];
                        st_wdata = i_value;
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_count = count_inc;
                    if (i_last) begin
                        n_run   = {2'b00, count_inc};
                        n_carry = 1'b0;
                        n_k     = '0;
                        if (count_inc < CW'(2)) begin
                            n_state = ST_OUT;
                        end else begin
                            n_state = ST_RUNLEN;
                        end
                    end
                end
            end

            ST_RUNLEN: begin
                if (32'(r_run) >= 32'(MIN_RUN_LIMIT)) begin
                    n_carry = r_carry | r_run[0];
                    n_run   = r_run >> 1;
                end else begin
                    n_run   = r_run + {{(XW-1){1'b0}}, r_carry};
                    n_lo    = '0;
                    n_state = ST_INS_RUN;
                end
            end

            ST_INS_RUN: begin
                if (r_lo >= n_ext) begin
                    n_size  = r_run;
                    n_state = ST_MRG_PASS;
                end else begin
                    n_hi    = (run_end > n_last) ? n_last : run_end;
                    n_i     = r_lo + XW'(1);
                    n_state = ST_INS_OUTER;
                end
            end

            ST_INS_OUTER: begin
                if (r_i > r_hi) begin
                    n_lo    = r_lo + r_run;
                    n_state = ST_INS_RUN;
                end else begin
                    st_raddr = r_i[AW-1:0];
                    n_j      = r_i;
                    n_state  = ST_INS_V;
                end
            end

            ST_INS_V: begin
                n_v      = st_rdata;
                st_raddr = AW'(r_j - XW'(1));
                n_state  = ST_INS_CMP;
            end

            ST_INS_CMP: begin
                if ($signed(st_rdata) > r_v) begin
                    // Shift the larger neighbor up one place.
                    st_we    = 1'b1;
                    st_waddr = r_j[AW-1:0];
                    st_wdata = st_rdata;
                    n_j      = r_j - XW'(1);
                    if (r_j - XW'(1) == r_lo) begin
                        n_state = ST_INS_PUT;
                    end else begin
                        st_raddr = AW'(r_j - XW'(2));
                    end
                end else begin
                    st_we    = 1'b1;
                    st_waddr = r_j[AW-1:0];
                    st_wdata = r_v;
                    n_i      = r_i + XW'(1);
                    n_state  = ST_INS_OUTER;
                end
            end

            ST_INS_PUT: begin
                st_we    = 1'b1;
                st_waddr = r_j[AW-1:0];
                st_wdata = r_v;
                n_i      = r_i + XW'(1);
                n_state  = ST_INS_OUTER;
            end

            ST_MRG_PASS: begin
                n_k = '0;
                if (r_size < n_ext) begin
                    n_lo    = '0;
                    n_state = ST_MRG_PAIR;
                end else begin
                    n_state = ST_OUT;
                end
            end

            ST_MRG_PAIR: begin
                if (r_lo >= n_ext) begin
                    n_size  = pair_step;
                    n_state = ST_MRG_PASS;
                end else begin
                    n_mid = pair_mid;
                    n_hi  = (pair_end > n_last) ? n_last : pair_end;
                    if (pair_mid < ((pair_end > n_last) ? n_last : pair_end)) begin
                        n_a      = r_lo;
                        n_b      = pair_mid + XW'(1);
                        n_k      = r_lo;
                        st_raddr = r_lo[AW-1:0];
                        n_state  = ST_MRG_FA;
                    end else begin
                        n_lo = r_lo + pair_step;
                    end
                end
            end

            ST_MRG_FA: begin
                n_va     = st_rdata;
                st_raddr = r_b[AW-1:0];
                n_state  = ST_MRG_WB;
            end

            ST_MRG_WA: begin
                n_va    = st_rdata;
                n_state = ST_MRG_CMP;
            end

            ST_MRG_WB: begin
                n_vb    = st_rdata;
                n_state = ST_MRG_CMP;
            end

            ST_MRG_CMP: begin
                sc_we    = 1'b1;
                sc_waddr = r_k[AW-1:0];
                n_k      = r_k + XW'(1);
                if (take_b) begin
                    sc_wdata = r_vb;
                    n_b      = r_b + XW'(1);
                    st_raddr = AW'(r_b + XW'(1));
                    n_state  = ST_MRG_WB;
                end else begin
                    sc_wdata = r_va;
                    n_a      = r_a + XW'(1);
                    st_raddr = AW'(r_a + XW'(1));
                    n_state  = ST_MRG_WA;
                end
                if (r_k == r_hi) begin
                    n_k     = r_lo;
                    n_state = ST_CPY;
                end
            end

            ST_CPY: begin
                sc_raddr = r_k[AW-1:0];
                n_wk     = r_k;
                n_cpv    = 1'b1;
                n_k      = r_k + XW'(1);
                if (r_k == r_hi) begin
                    n_state = ST_CPY_END;
                end
            end

            ST_CPY_END: begin
                n_lo    = r_lo + pair_step;
                n_state = ST_MRG_PAIR;
            end

            ST_OUT: begin
                st_raddr = r_k[AW-1:0];
                n_emit   = 1'b1;
                n_elast  = (r_k == n_last);
                n_k      = r_k + XW'(1);
                if (r_k == n_last) begin
                    n_state = ST_OUT_END;
                end
            end

            ST_OUT_END: begin
                // The final beat is on the outputs during this cycle.
                n_count = '0;
                n_drop  = 1'b0;
                n_state = ST_LOAD;
            end

            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_cpv   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_cpv   <= n_cpv;
            r_emit  <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_carry <= n_carry;
        r_size  <= n_size;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_i     <= n_i;
        r_j     <= n_j;
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_wk    <= n_wk;
        r_elast <= n_elast;
        r_v     <= n_v;
        r_va    <= n_va;
        r_vb    <= n_vb;
    end

endmodule

FILE: src/tsbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tsbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the block sorter: directed sets, then random sets.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsbs_pkg::*;

    // One result beat as the sorter should send it.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_beat;

    // One row of the directed table. When n_typed is nonzero, the results of the
    // set that this row closes are typed in here (at most two of them) rather
    // than taken from the predictor.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     fin;
        logic [1:0]               n_typed;
        logic signed [DATA_W-1:0] want_lo;
        logic signed [DATA_W-1:0] want_hi;
    } t_stim_row;

    localparam int ITEM_TARGET = 230;
    localparam int N_DIRECTED  = 22;

    // The directed sets: lone values at zero and at both extremes, pairs that
    // cross the sign boundary, equal values, alternating bit patterns, a set in
    // descending order and a set mixing all the extremes.
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{32'sh0000_0000, 1'b1, 2'd1, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh7FFF_FFFF, 1'b1, 2'd1, 32'sh7FFF_FFFF, 32'sh0000_0000},
        '{32'sh8000_0000, 1'b1, 2'd1, 32'sh8000_0000, 32'sh0000_0000},
        '{32'sh7FFF_FFFF, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh8000_0000, 1'b1, 2'd2, 32'sh8000_0000, 32'sh7FFF_FFFF},
        '{32'shFFFF_FFFF, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0001, 1'b1, 2'd2, 32'shFFFF_FFFF, 32'sh0000_0001},
        '{32'sh0000_0005, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0005, 1'b1, 2'd2, 32'sh0000_0005, 32'sh0000_0005},
        '{32'sh5555_5555, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'shAAAA_AAAA, 1'b1, 2'd2, 32'shAAAA_AAAA, 32'sh5555_5555},
        '{32'sh0000_0004, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0003, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0002, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0001, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0000, 1'b1, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh8000_0000, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh7FFF_FFFF, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'shFFFF_FFFF, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0000, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh0000_0001, 1'b0, 2'd0, 32'sh0000_0000, 32'sh0000_0000},
        '{32'sh8000_0000, 1'b1, 2'd0, 32'sh0000_0000, 32'sh0000_0000}
    };

    // Every input of the sorter starts at a known value, with reset asserted.
    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start   = 1'b0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_last  = 1'b0;
    logic                     busy;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_last_out;
    logic                     o_overflow;

    // Predictor state: the values of the set being loaded, whether any beat of
    // this set was dropped, and the sorted beats still owed by the sorter.
    logic signed [DATA_W-1:0] held_values [$];
    logic                     spill_seen = 1'b0;
    t_sorted_beat             pending_sorted [$];
    int                       error_count = 0;

    always #5 i_clk = ~i_clk;

    timsort_block_sorter_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Takes in one accepted beat. A beat that finds the store full is dropped
    // and marks the set. On the closing beat the held set is put in ascending
    // order by insertion (the output of the sorter does not depend on how it
    // orders equal values, since they are identical), queued as result beats,
    // and the set state is cleared for the next set.
    task automatic absorb_item(input logic signed [DATA_W-1:0] v, input logic fin,
                               input logic [1:0] n_typed,
                               input logic signed [DATA_W-1:0] want_lo,
                               input logic signed [DATA_W-1:0] want_hi);
        logic signed [DATA_W-1:0] ordered [$];
        t_sorted_beat             beat;
        int                       pos;
        if (held_values.size() < MAX_ITEMS_DEF) begin
            held_values.push_back(v);
        end else begin
            spill_seen = 1'b1;
        end
        if (fin) begin
            if (n_typed != 2'd0) begin
                // Results typed in by hand: the smallest first, then the largest.
                beat = '{want_lo, n_typed == 2'd1, 1'b0};
                pending_sorted.push_back(beat);
                if (n_typed == 2'd2) begin
                    beat = '{want_hi, 1'b1, 1'b0};
                    pending_sorted.push_back(beat);
                end
            end else begin
                foreach (held_values[i]) begin
                    pos = ordered.size();
                    while (pos > 0 && ordered[pos-1] > held_values[i]) begin
                        pos--;
                    end
                    ordered.insert(pos, held_values[i]);
                end
                foreach (ordered[i]) begin
                    beat = '{ordered[i], i == ordered.size() - 1, spill_seen};
                    pending_sorted.push_back(beat);
                end
            end
            held_values.delete();
            spill_seen = 1'b0;
        end
    endtask

    // Presents one beat and holds it until the sorter takes it at an edge where
    // busy is low. Start stays high into the next beat when there is no gap, so
    // it is never lowered and raised within one time step.
    task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic fin,
                             input logic [1:0] n_typed,
                             input logic signed [DATA_W-1:0] want_lo,
                             input logic signed [DATA_W-1:0] want_hi,
                             input int gap);
        start   <= 1'b1;
        i_value <= v;
        i_last  <= fin;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        absorb_item(v, fin, n_typed, want_lo, want_hi);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Idle cycles between beats: mostly none or a few, now and then a long one,
    // so that gaps land on loading as well as on every stage of the sort.
    function automatic int idle_gap();
        if ($urandom_range(0, 9) < 6) begin
            return 0;
        end else if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Values: the two extremes, a narrow band around zero that makes equal
    // values common, and the full 32-bit range so every bit toggles.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3: return $signed($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Every result beat is compared with the oldest one owed. The sorter gives
    // no way to hold results off, so each strobe is taken at the edge that ends
    // its cycle; the fields are read here before that edge updates them.
    always @(posedge i_clk) begin : check_results
        t_sorted_beat want;
        if (i_rst_n && o_valid) begin
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, value %0d",
                                          o_sorted_value));
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_value !== want.value) begin
                    report_mismatch($sformatf("sorted value %0d, expected %0d",
                                              o_sorted_value, want.value));
                end
                if (o_last_out !== want.last) begin
                    report_mismatch($sformatf("last mark %b, expected %b",
                                              o_last_out, want.last));
                end
                if (o_overflow !== want.ovf) begin
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              o_overflow, want.ovf));
                end
            end
        end
    end

    initial begin : stimulus
        int set_no;
        int set_len;
        int items_sent;
        bit no_idle;
        items_sent = N_DIRECTED;

        // Reset is held from the start and released at a clock edge.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets, walked row by row with random idling in between.
        foreach (DIRECTED[r]) begin
            send_beat(DIRECTED[r].value, DIRECTED[r].fin, DIRECTED[r].n_typed,
                      DIRECTED[r].want_lo, DIRECTED[r].want_hi, idle_gap());
        end

        // Random sets. A full set of MAX_ITEMS is the only size that reaches
        // the merge passes (the run length of smaller sets covers them whole),
        // so one exactly full set and one that overflows by two are scheduled;
        // in the latter the closing beat itself is dropped and the sort must
        // still start. Other sets are mostly short, some up to one below full.
        for (set_no = 0; set_no < 8 || items_sent < ITEM_TARGET; set_no++) begin
            if (set_no == 2) begin
                set_len = MAX_ITEMS_DEF;
            end else if (set_no == 6) begin
                set_len = MAX_ITEMS_DEF + 2;
            end else if ($urandom_range(0, 4) == 0) begin
                set_len = $urandom_range(11, MAX_ITEMS_DEF - 1);
            end else begin
                set_len = $urandom_range(1, 10);
            end

            // Past the scheduled sets, the final set is trimmed to the target.
            if (set_no >= 8 && set_len > ITEM_TARGET - items_sent) begin
                set_len = ITEM_TARGET - items_sent;
            end

            // Once, the sender goes quiet until the sorter has sent everything.
            if (set_no == 4) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_sorted.size() != 0) begin
                    @(posedge i_clk);
                end
            end

            // Some sets go back to back with no idle cycles at all.
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++) begin
                send_beat(pick_value(), k == set_len - 1, 2'd0, '0, '0,
                          no_idle ? 0 : idle_gap());
            end
            items_sent += set_len;
        end

        // Drain: wait for every owed beat, then keep the clock running so that any
        // stray beat would still be caught.
        start <= 1'b0;
        while (pending_sorted.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Guard against a hung sorter. The time limit leaves a wide margin over the
    // time that all the sets of this bench take.
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
